FILE: src/vtp_pkg.sv
// Shared constants and types for the vertex transform block.
`timescale 1ns / 1ps
package vtp_pkg;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_REGS        = 8;
    localparam int REG_WIDTH       = 64;
    localparam int IDX_WIDTH       = 3;
    localparam int PORT_WIDTH      = 32;

    localparam logic [IDX_WIDTH-1:0] REG_R0_C01 = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_R0_C23 = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_R1_C01 = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_R1_C23 = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_R2_C01 = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_R2_C23 = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_R3_C01 = 3'd6;
    localparam logic [IDX_WIDTH-1:0] REG_R3_C23 = 3'd7;

    // lane status handed from the dot-product lanes to the merge stage
    typedef struct packed {
        logic valid;
        logic kind;
        logic sat;
    } t_lane_ctl;
endpackage

FILE: src/vtp_dot_lane.sv
// One matrix row times the vertex: four products, exact sum, floor scale, clamp.
`timescale 1ns / 1ps
module vtp_dot_lane #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic signed [VALUE_WIDTH-1:0] i_m0,
    input  logic signed [VALUE_WIDTH-1:0] i_m1,
    input  logic signed [VALUE_WIDTH-1:0] i_m2,
    input  logic signed [VALUE_WIDTH-1:0] i_m3,
    input  logic signed [VALUE_WIDTH-1:0] i_v0,
    input  logic signed [VALUE_WIDTH-1:0] i_v1,
    input  logic signed [VALUE_WIDTH-1:0] i_v2,
    input  logic signed [VALUE_WIDTH-1:0] i_v3,
    output logic signed [VALUE_WIDTH-1:0] o_t,
    output logic                          o_sat
);
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [SW-1:0] n_sum, n_sh;
    logic signed [VALUE_WIDTH-1:0] r_t;
    logic r_sat;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        r_p0 <= PW'(i_m0) * PW'(i_v0);
        r_p1 <= PW'(i_m1) * PW'(i_v1);
        r_p2 <= PW'(i_m2) * PW'(i_v2);
        r_p3 <= PW'(i_m3) * PW'(i_v3);
    end

    // floor of the exact sum equals the sum of product floors plus the
    // floor of the summed fraction parts
    always_comb begin
        n_sum = SW'(r_p0) + SW'(r_p1) + SW'(r_p2) + SW'(r_p3);
        n_sh  = n_sum >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (n_sh > VMAX) begin
            r_t <= VMAX[VALUE_WIDTH-1:0];
            r_sat <= 1'b1;
        end else if (n_sh < VMIN) begin
            r_t <= VMIN[VALUE_WIDTH-1:0];
            r_sat <= 1'b1;
        end else begin
            r_t <= n_sh[VALUE_WIDTH-1:0];
            r_sat <= 1'b0;
        end
    end

    assign o_t = r_t;
    assign o_sat = r_sat;
endmodule

FILE: src/vtp_div_pipe.sv
// Pipelined signed restoring divider, one quotient bit per stage, with clamp.
`timescale 1ns / 1ps
module vtp_div_pipe #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic signed [VALUE_WIDTH-1:0] i_num,
    input  logic signed [VALUE_WIDTH-1:0] i_den,
    output logic signed [VALUE_WIDTH-1:0] o_q,
    output logic                          o_sat
);
    localparam int NW = VALUE_WIDTH + FRAC_BITS;   // dividend magnitude bits
    localparam int DW = VALUE_WIDTH;               // divisor magnitude bits
    localparam int RW = DW + 1;
    localparam logic [NW:0] QMAX = (NW+1)'((64'd1 << (VALUE_WIDTH - 1)) - 1);

    logic [NW-1:0] r_q   [0:NW];
    logic [RW-1:0] r_rem [0:NW];
    logic [DW-1:0] r_d   [0:NW];
    logic          r_neg [0:NW];
    logic signed [VALUE_WIDTH-1:0] r_out;
    logic r_sat;
    logic [NW-1:0] n_na;
    logic [DW-1:0] n_da;
    logic [NW:0] n_mag;

    always_comb begin
        n_na = i_num[VALUE_WIDTH-1] ? (NW'(~i_num) + NW'(1)) << FRAC_BITS
                                    : {i_num, {FRAC_BITS{1'b0}}};
        n_da = i_den[VALUE_WIDTH-1] ? DW'(-i_den) : DW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        r_q[0]   <= n_na;
        r_rem[0] <= '0;
        r_d[0]   <= n_da;
        r_neg[0] <= i_num[VALUE_WIDTH-1] ^ i_den[VALUE_WIDTH-1];
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [RW-1:0] n_r, n_t;
        always_comb begin
            n_r = {r_rem[s][RW-2:0], r_q[s][NW-1]};
            n_t = n_r - {1'b0, r_d[s]};
        end
        always_ff @(posedge i_clk) begin
            r_d[s+1]   <= r_d[s];
            r_neg[s+1] <= r_neg[s];
            if (!n_t[RW-1]) begin
                r_rem[s+1] <= n_t;
                r_q[s+1]   <= {r_q[s][NW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_r;
                r_q[s+1]   <= {r_q[s][NW-2:0], 1'b0};
            end
        end
    end

    always_comb n_mag = {1'b0, r_q[NW]};

    always_ff @(posedge i_clk) begin
        if (r_neg[NW]) begin
            if (n_mag > QMAX + (NW+1)'(1)) begin
                r_out <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                r_sat <= 1'b1;
            end else begin
                r_out <= VALUE_WIDTH'(-n_mag);
                r_sat <= 1'b0;
            end
        end else if (n_mag > QMAX) begin
            r_out <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            r_sat <= 1'b1;
        end else begin
            r_out <= VALUE_WIDTH'(n_mag);
            r_sat <= 1'b0;
        end
    end

    assign o_q = r_out;
    assign o_sat = r_sat;
endmodule

FILE: src/vertex_transform_project.sv
// Top level: matrix registers, four row lanes, divide lanes and merge.
// One vertex per clock: start may be high every cycle with busy always low.
// Results appear on the o_ ports with o_done high, in the order of acceptance;
// the delay is set by
// the bit-per-stage divider pipeline, and the transform-only path is delayed
// to match so words leave in order. The receiver cannot stall the output.
`timescale 1ns / 1ps
module vertex_transform_project #(
    parameter int VALUE_WIDTH = vtp_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = vtp_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [vtp_pkg::IDX_WIDTH-1:0]       i_cfg_idx,
    input  logic [vtp_pkg::REG_WIDTH-1:0]       i_cfg_data,
    input  logic                                i_kind,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_x,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_y,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_z,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_w,
    output logic                                o_done,
    output logic signed [vtp_pkg::PORT_WIDTH-1:0] o_out_x,
    output logic signed [vtp_pkg::PORT_WIDTH-1:0] o_out_y,
    output logic signed [vtp_pkg::PORT_WIDTH-1:0] o_out_z,
    output logic signed [vtp_pkg::PORT_WIDTH-1:0] o_out_w,
    output logic                                o_divided,
    output logic                                o_saturated
);
    import vtp_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int DLAT = VALUE_WIDTH + FRAC_BITS + 2;  // divider latency
    localparam int TLAT = 2;                            // lane latency
    localparam logic [REG_WIDTH-1:0] ONE_LO = REG_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic [REG_WIDTH-1:0] ONE_HI = REG_WIDTH'(64'd1 << (FRAC_BITS + 32));

    logic [REG_WIDTH-1:0] r_mat [0:NUM_REGS-1];
    logic signed [VW-1:0] n_m [0:3][0:3];
    logic signed [VW-1:0] n_v [0:3];
    logic signed [VW-1:0] n_t [0:3];
    logic [3:0] n_tsat;
    logic take;

    assign busy = 1'b0;
    assign take = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                if (k == int'(REG_R0_C01) || k == int'(REG_R2_C23))
                    r_mat[k] <= ONE_LO;
                else if (k == int'(REG_R1_C01) || k == int'(REG_R3_C23))
                    r_mat[k] <= ONE_HI;
                else
                    r_mat[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_m[r][0] = r_mat[2*r][VW-1:0];
            n_m[r][1] = r_mat[2*r][32+VW-1:32];
            n_m[r][2] = r_mat[2*r+1][VW-1:0];
            n_m[r][3] = r_mat[2*r+1][32+VW-1:32];
        end
        n_v[0] = i_in_x[VW-1:0];
        n_v[1] = i_in_y[VW-1:0];
        n_v[2] = i_in_z[VW-1:0];
        n_v[3] = i_in_w[VW-1:0];
    end

    for (genvar r = 0; r < 4; r++) begin : g_lane
        vtp_dot_lane #(.VALUE_WIDTH(VW), .FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk(i_clk),
            .i_m0(n_m[r][0]), .i_m1(n_m[r][1]), .i_m2(n_m[r][2]), .i_m3(n_m[r][3]),
            .i_v0(n_v[0]), .i_v1(n_v[1]), .i_v2(n_v[2]), .i_v3(n_v[3]),
            .o_t(n_t[r]), .o_sat(n_tsat[r])
        );
    end

    // control travels alongside the lanes
    t_lane_ctl r_ctl [0:TLAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TLAT; k++) r_ctl[k] <= '0;
        end else begin
            r_ctl[0] <= '{valid: take, kind: i_kind, sat: 1'b0};
            for (int k = 1; k < TLAT; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    logic signed [VW-1:0] n_q [0:2];
    logic [2:0] n_qsat;
    for (genvar r = 0; r < 3; r++) begin : g_div
        vtp_div_pipe #(.VALUE_WIDTH(VW), .FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk(i_clk), .i_num(n_t[r]), .i_den(n_t[3]),
            .o_q(n_q[r]), .o_sat(n_qsat[r])
        );
    end

    // delay the transformed words and flags to match the divider
    logic signed [VW-1:0] r_dt [0:DLAT-1][0:3];
    t_lane_ctl r_dctl [0:DLAT-1];
    logic r_ddiv [0:DLAT-1];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DLAT; k++) begin
            for (int c = 0; c < 4; c++)
                r_dt[k][c] <= (k == 0) ? n_t[c] : r_dt[k-1][c];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLAT; k++) begin
                r_dctl[k] <= '0;
                r_ddiv[k] <= 1'b0;
            end
        end else begin
            r_dctl[0] <= '{valid: r_ctl[TLAT-1].valid, kind: r_ctl[TLAT-1].kind,
                          sat: |n_tsat};
            r_ddiv[0] <= r_ctl[TLAT-1].kind && (n_t[3] != '0);
            for (int k = 1; k < DLAT; k++) begin
                r_dctl[k] <= r_dctl[k-1];
                r_ddiv[k] <= r_ddiv[k-1];
            end
        end
    end

    // merge stage
    logic r_done, r_div, r_sat;
    logic signed [VW-1:0] r_o [0:3];
    logic n_div;
    assign n_div = r_ddiv[DLAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dctl[DLAT-1].valid;
        end
        r_div <= n_div;
        r_sat <= r_dctl[DLAT-1].sat | (n_div & (|n_qsat));
        for (int c = 0; c < 3; c++) r_o[c] <= n_div ? n_q[c] : r_dt[DLAT-1][c];
        r_o[3] <= r_dt[DLAT-1][3];
    end

    assign o_done = r_done;
    assign o_out_x = PORT_WIDTH'(r_o[0]);
    assign o_out_y = PORT_WIDTH'(r_o[1]);
    assign o_out_z = PORT_WIDTH'(r_o[2]);
    assign o_out_w = PORT_WIDTH'(r_o[3]);
    assign o_divided = r_div;
    assign o_saturated = r_sat;

    a_never_busy: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");
    a_div_needs_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_divided |-> o_out_w != '0)
        else $error("divide with zero w");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_dctl[DLAT-1].valid))
        else $error("result without item");
endmodule

FILE: tb/sv/vertex_transform_project_checker.sv
// Checker: predicts each transformed vertex and compares it with the block's output.
`timescale 1ns / 1ps
module vertex_transform_project_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic                                 i_cfg_we,
    input  logic [vtp_pkg::IDX_WIDTH-1:0]        i_cfg_idx,
    input  logic [vtp_pkg::REG_WIDTH-1:0]        i_cfg_data,
    input  logic                                 i_kind,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_x,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_y,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_z,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_in_w,
    input  logic                                 i_done,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_out_x,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_out_y,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_out_z,
    input  logic signed [vtp_pkg::PORT_WIDTH-1:0] i_out_w,
    input  logic                                 i_divided,
    input  logic                                 i_saturated,
    output int                                   o_errors,
    output int                                   o_pending
);
    import vtp_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint VMAX = 64'sh7FFF_FFFF;
    localparam longint VMIN = -64'sh8000_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        divided;
        logic        saturated;
    } t_vertex_out;

    logic [REG_WIDTH-1:0] matrix [NUM_REGS];
    t_vertex_out          vertex_q[$];

    function automatic longint sat_clip(longint v, ref logic sat);
        if (v > VMAX) begin
            sat = 1'b1;
            return VMAX;
        end
        if (v < VMIN) begin
            sat = 1'b1;
            return VMIN;
        end
        return v;
    endfunction

    function automatic t_vertex_out transform_vertex(logic kind, logic [31:0] vx,
            logic [31:0] vy, logic [31:0] vz, logic [31:0] vw);
        longint      comp [4];
        longint      row_out [4];
        longint      acc;
        longint      coef;
        logic [63:0] reg_val;
        logic        sat;
        logic        dv;
        t_vertex_out res;
        comp[0] = longint'(signed'(vx));
        comp[1] = longint'(signed'(vy));
        comp[2] = longint'(signed'(vz));
        comp[3] = longint'(signed'(vw));
        sat = 1'b0;
        dv = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) begin
                reg_val = matrix[r * 2 + c / 2];
                coef = (c % 2) ? longint'(signed'(reg_val[63:32]))
                               : longint'(signed'(reg_val[31:0]));
                // full sum fits in 66 bits at most; 4 * 2^62 would not fit, so
                // sum the floors and fraction parts apart (the block shifts its exact sum)
                acc += (coef * comp[c]) >>> FRAC;
            end
            row_out[r] = acc;
        end
        // fraction carry: recompute exactly
        for (int r = 0; r < 4; r++) begin
            longint fr;
            fr = 0;
            for (int c = 0; c < 4; c++) begin
                reg_val = matrix[r * 2 + c / 2];
                coef = (c % 2) ? longint'(signed'(reg_val[63:32]))
                               : longint'(signed'(reg_val[31:0]));
                fr += (coef * comp[c]) & ((64'sd1 <<< FRAC) - 1);
            end
            row_out[r] = sat_clip(row_out[r] + (fr >>> FRAC), sat);
        end
        if (kind && row_out[3] != 0) begin
            dv = 1'b1;
            for (int r = 0; r < 3; r++)
                row_out[r] = sat_clip((row_out[r] * (64'sd1 <<< FRAC)) / row_out[3], sat);
        end
        res.x = row_out[0][31:0];
        res.y = row_out[1][31:0];
        res.z = row_out[2][31:0];
        res.w = row_out[3][31:0];
        res.divided = dv;
        res.saturated = sat;
        return res;
    endfunction

    task automatic report(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            o_errors++;
        end
    endtask

    assign o_pending = vertex_q.size();

    always @(posedge i_clk) begin
        t_vertex_out want;
        if (!i_rst_n) begin
            matrix[0] <= 64'h0000_0000_0001_0000;
            matrix[1] <= '0;
            matrix[2] <= 64'h0001_0000_0000_0000;
            matrix[3] <= '0;
            matrix[4] <= '0;
            matrix[5] <= 64'h0000_0000_0001_0000;
            matrix[6] <= '0;
            matrix[7] <= 64'h0001_0000_0000_0000;
            vertex_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we)
                matrix[i_cfg_idx] <= i_cfg_data;
            if (i_start && !i_busy)
                vertex_q.push_back(transform_vertex(i_kind, i_in_x, i_in_y, i_in_z, i_in_w));
            if (i_done) begin
                if (vertex_q.size() == 0) begin
                    $display("%0t: unexpected word expected none actual %h", $time, i_out_x);
                    o_errors++;
                end else begin
                    want = vertex_q.pop_front();
                    report("x", want.x, i_out_x);
                    report("y", want.y, i_out_y);
                    report("z", want.z, i_out_z);
                    report("w", want.w, i_out_w);
                    report("divided", want.divided, i_divided);
                    report("saturated", want.saturated, i_saturated);
                end
            end
        end
    end
endmodule

FILE: tb/sv/vertex_transform_project_test.sv
// Testbench top: drives vertices and matrix writes, reports the verdict.
`timescale 1ns / 1ps
module vertex_transform_project_test;
    import vtp_pkg::*;

    localparam int LATENCY   = 52;
    localparam int MAX_CYCLE = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cfg_we = 1'b0;
    logic [IDX_WIDTH-1:0]  i_cfg_idx = '0;
    logic [REG_WIDTH-1:0]  i_cfg_data = '0;
    logic                  i_kind = 1'b0;
    logic signed [31:0]    i_in_x = '0, i_in_y = '0, i_in_z = '0, i_in_w = '0;
    logic                  o_done, o_divided, o_saturated;
    logic signed [31:0]    o_out_x, o_out_y, o_out_z, o_out_w;
    int                    errors, pending;
    int                    cycle = 0;

    always #5 i_clk = ~i_clk;

    vertex_transform_project u_top (.*);

    vertex_transform_project_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .i_kind, .i_in_x, .i_in_y, .i_in_z, .i_in_w, .i_done(o_done),
        .i_out_x(o_out_x), .i_out_y(o_out_y), .i_out_z(o_out_z), .i_out_w(o_out_w),
        .i_divided(o_divided), .i_saturated(o_saturated), .o_errors(errors),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("vertex_transform_project_test NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    // caller drops the write enable after the last write
    task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // word with idle gap drawn per item; start held across back-to-back words
    task automatic send_vertex(logic kind, logic [31:0] vx, logic [31:0] vy,
            logic [31:0] vz, logic [31:0] vw, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_kind <= kind;
        i_in_x <= vx;
        i_in_y <= vy;
        i_in_z <= vz;
        i_in_w <= vw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_matrix(int mode);
        for (int r = 0; r < NUM_REGS; r++) begin
            case (mode)
                0: write_reg(r[IDX_WIDTH-1:0], {2{32'h7FFF_FFFF}});
                1: write_reg(r[IDX_WIDTH-1:0], {2{32'h8000_0000}});
                2: write_reg(r[IDX_WIDTH-1:0], '0);
                3: write_reg(r[IDX_WIDTH-1:0], {pick_value(), pick_value()});
                default: write_reg(r[IDX_WIDTH-1:0],
                    {32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000,
                     32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000});
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity matrix: extremes, zero w, divide and no divide
        send_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 0);
        send_vertex(1'b1, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 32'h0, 0);
        send_vertex(1'b1, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 32'h0002_0000, 0);
        send_vertex(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0000_0001, 1);
        send_vertex(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_vertex(1'b1, 32'h8000_0000, 32'h1, 32'h0, 32'h8000_0000, 1);
        send_vertex(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        drain();
        // saturating matrices and the zero matrix
        for (int m = 0; m < 3; m++) begin
            load_matrix(m);
            send_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
            send_vertex(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
            send_vertex(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 1);
            send_vertex(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1);
            drain();
        end

        for (int ph = 0; ph < 10; ph++) begin
            load_matrix((ph % 4 == 0) ? 3 : 4);
            for (int n = 0; n < 110; n++)
                send_vertex($urandom_range(0, 3) != 0, pick_value(), pick_value(),
                            pick_value(), pick_value(), (ph % 3) != 0);
            drain();
        end

        start <= 1'b0;
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("vertex_transform_project_test OK");
        else
            $display("vertex_transform_project_test NOT OK");
        $finish;
    end
endmodule
